// ===== rtl/dcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and constants for the synthesizer command framer.
// ----------------------------------------------------------------------------
`default_nettype none

package dcf_pkg;

  localparam int unsigned HZ_W       = 28;
  localparam int unsigned SCALE_W    = 36;
  localparam int unsigned SCALE_LO_W = 18;
  localparam int unsigned SCALE_HI_W = SCALE_W - SCALE_LO_W;
  localparam int unsigned PP_W       = HZ_W + SCALE_LO_W;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 64;

  localparam logic [APB_ADDR_W-1:0] CFG_ADDR_SCALE = 3'd0;
  localparam logic [SCALE_W-1:0]    SCALE_RESET    = 36'd36893488147;

  localparam logic [7:0]  ADDR_CHAN_SEL = 8'h00;
  localparam logic [7:0]  ADDR_FREQ     = 8'h04;
  localparam logic [7:0]  ADDR_PHASE    = 8'h05;
  localparam logic [7:0]  ADDR_AMPL     = 8'h06;
  localparam logic [15:0] AMPL_ENABLE   = 16'h1000;

  // byte positions within one item's output
  localparam logic [2:0] IDX_SEL_ADDR = 3'd0;
  localparam logic [2:0] IDX_SEL_DATA = 3'd1;
  localparam logic [2:0] IDX_REG_ADDR = 3'd2;
  localparam logic [2:0] IDX_DATA0    = 3'd3;
  localparam logic [2:0] IDX_LAST_FRQ = 3'd6;
  localparam logic [2:0] IDX_LAST_PHS = 3'd4;
  localparam logic [2:0] IDX_LAST_AMP = 3'd5;

  typedef enum logic [1:0] {
    OP_FREQ  = 2'd0,
    OP_PHASE = 2'd1,
    OP_AMPL  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  mask;
    logic [13:0] phase;
    logic [9:0]  ampl;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dds_channel_command_framer_top.sv =====
// ----------------------------------------------------------------------------
// dds_channel_command_framer_top
// Turns one synthesizer command into the bus bytes of its two frames.
// Stages: input register, tuning word stage, byte sequencer, output register.
// One byte per cycle within an item; an item has 7 (frequency), 5 (phase) or
// 6 (amplitude) bytes, set by the byte sequencer; the tuning word stage drops
// undefined ops. The receiver cannot stall. Reset clears all valid flags and
// loads the default tuning scale.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_channel_command_framer_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     op_i,
  input  wire logic [3:0]                     channel_mask_i,
  input  wire logic [dcf_pkg::HZ_W-1:0]       frequency_hz_i,
  input  wire logic [13:0]                    phase_word_i,
  input  wire logic [9:0]                     amplitude_word_i,
  output logic                                result_valid_o,
  output logic [7:0]                          bus_byte_o,
  output logic                                frame_start_o,
  output logic                                frame_end_o,
  output logic                                last_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dcf_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [dcf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dcf_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  logic                        scale_q;
  logic [dcf_pkg::SCALE_W-1:0] tuning_scale_q;
  logic                        cfg_wr;

  logic                        s1_valid_q, s1_valid_d;
  dcf_pkg::cmd_t               s1_cmd_q;
  logic [dcf_pkg::HZ_W-1:0]    s1_hz_q;
  logic                        accept;

  logic                        s2_free;
  logic                        s2_valid;
  dcf_pkg::cmd_t               s2_cmd;
  logic [31:0]                 s2_word;
  logic                        em_ready;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr == dcf_pkg::CFG_ADDR_SCALE);
  assign scale_q = 1'b0;
  assign prdata  = (paddr == dcf_pkg::CFG_ADDR_SCALE) ?
                   {{(dcf_pkg::APB_DATA_W-dcf_pkg::SCALE_W){scale_q}}, tuning_scale_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuning_scale_q <= dcf_pkg::SCALE_RESET;
    end else if (cfg_wr) begin
      tuning_scale_q <= pwdata[dcf_pkg::SCALE_W-1:0];
    end
  end

  // input register
  assign busy       = s1_valid_q && !s2_free;
  assign accept     = start && !busy;
  assign s1_valid_d = accept || (s1_valid_q && !s2_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q.op    <= op_i;
      s1_cmd_q.mask  <= channel_mask_i;
      s1_cmd_q.phase <= phase_word_i;
      s1_cmd_q.ampl  <= amplitude_word_i;
      s1_hz_q        <= frequency_hz_i;
    end
  end

  dcf_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_cmd_i    (s1_cmd_q),
    .hz_i        (s1_hz_q),
    .scale_i     (tuning_scale_q),
    .take_i      (em_ready),
    .free_o      (s2_free),
    .out_valid_o (s2_valid),
    .out_cmd_o   (s2_cmd),
    .word_o      (s2_word)
  );

  dcf_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s2_valid),
    .in_cmd_i       (s2_cmd),
    .word_i         (s2_word),
    .ready_o        (em_ready),
    .result_valid_o (result_valid_o),
    .bus_byte_o     (bus_byte_o),
    .frame_start_o  (frame_start_o),
    .frame_end_o    (frame_end_o),
    .last_o         (last_o)
  );

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> frame_end_o)
    else $error("last byte without frame end");

  a_start_is_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && frame_start_o |->
      (bus_byte_o == dcf_pkg::ADDR_CHAN_SEL) || (bus_byte_o == dcf_pkg::ADDR_FREQ) ||
      (bus_byte_o == dcf_pkg::ADDR_PHASE) || (bus_byte_o == dcf_pkg::ADDR_AMPL))
    else $error("frame start on a non-address byte");

  a_next_item_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) ##1 result_valid_o |->
      frame_start_o && (bus_byte_o == dcf_pkg::ADDR_CHAN_SEL))
    else $error("item does not open with channel select");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> s1_valid_q)
    else $error("input register lost an item while busy");

endmodule

`default_nettype wire

// ===== rtl/dcf_mult.sv =====
// ----------------------------------------------------------------------------
// dcf_mult
// Tuning word stage: two registered partial products, summed on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_mult (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire dcf_pkg::cmd_t               in_cmd_i,
  input  wire logic [dcf_pkg::HZ_W-1:0]    hz_i,
  input  wire logic [dcf_pkg::SCALE_W-1:0] scale_i,
  input  wire logic                        take_i,
  output logic                             free_o,
  output logic                             out_valid_o,
  output dcf_pkg::cmd_t                    out_cmd_o,
  output logic [31:0]                      word_o
);

  logic                        valid_q, valid_d;
  dcf_pkg::cmd_t               cmd_q;
  logic [dcf_pkg::PP_W-1:0]    pp_lo_q, pp_hi_q;
  logic                        op_ok;
  logic [63:0]                 prod;

  assign free_o = !valid_q || take_i;
  assign op_ok  = (in_cmd_i.op == dcf_pkg::OP_FREQ) ||
                  (in_cmd_i.op == dcf_pkg::OP_PHASE) ||
                  (in_cmd_i.op == dcf_pkg::OP_AMPL);

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = in_valid_i && op_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && in_valid_i) begin
      cmd_q   <= in_cmd_i;
      pp_lo_q <= hz_i * scale_i[dcf_pkg::SCALE_LO_W-1:0];
      pp_hi_q <= hz_i * scale_i[dcf_pkg::SCALE_W-1:dcf_pkg::SCALE_LO_W];
    end
  end

  assign prod        = {{(64-dcf_pkg::PP_W){1'b0}}, pp_lo_q}
                     + {pp_hi_q, {dcf_pkg::SCALE_LO_W{1'b0}}};
  assign word_o      = prod[63:32];
  assign out_valid_o = valid_q;
  assign out_cmd_o   = cmd_q;

endmodule

`default_nettype wire

// ===== rtl/dcf_emit.sv =====
// ----------------------------------------------------------------------------
// dcf_emit
// Byte sequencer: walks the two frames of one item, registered result out.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_emit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire dcf_pkg::cmd_t in_cmd_i,
  input  wire logic [31:0]   word_i,
  output logic               ready_o,
  output logic               result_valid_o,
  output logic [7:0]         bus_byte_o,
  output logic               frame_start_o,
  output logic               frame_end_o,
  output logic               last_o
);

  logic        busy_q, busy_d;
  logic [2:0]  idx_q, idx_d;
  logic [1:0]  op_q;
  logic [3:0]  mask_q;
  logic [31:0] data_q, data_d;
  logic [15:0] ampl_ext;
  logic        load;
  logic        at_last;
  logic [2:0]  last_idx;
  logic [7:0]  reg_addr;
  logic [1:0]  dsel;
  logic [7:0]  byte_d;
  logic        start_d, end_d;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_start_q, out_end_q, out_last_q;

  always_comb begin
    case (op_q)
      dcf_pkg::OP_FREQ: begin
        last_idx = dcf_pkg::IDX_LAST_FRQ;
        reg_addr = dcf_pkg::ADDR_FREQ;
      end
      dcf_pkg::OP_PHASE: begin
        last_idx = dcf_pkg::IDX_LAST_PHS;
        reg_addr = dcf_pkg::ADDR_PHASE;
      end
      dcf_pkg::OP_AMPL: begin
        last_idx = dcf_pkg::IDX_LAST_AMP;
        reg_addr = dcf_pkg::ADDR_AMPL;
      end
      default: begin
        last_idx = dcf_pkg::IDX_LAST_FRQ;
        reg_addr = dcf_pkg::ADDR_FREQ;
      end
    endcase
  end

  assign at_last = busy_q && (idx_q == last_idx);
  assign ready_o = !busy_q || at_last;
  assign load    = in_valid_i && ready_o;

  // first byte in [31:24]; amplitude data in [23:8], below a zero byte
  assign ampl_ext = {6'd0, in_cmd_i.ampl} | dcf_pkg::AMPL_ENABLE;

  always_comb begin
    case (in_cmd_i.op)
      dcf_pkg::OP_FREQ:  data_d = word_i;
      dcf_pkg::OP_PHASE: data_d = {2'b00, in_cmd_i.phase, 16'h0000};
      dcf_pkg::OP_AMPL:  data_d = {8'h00, ampl_ext, 8'h00};
      default:           data_d = word_i;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = dcf_pkg::IDX_SEL_ADDR;
    end else if (at_last) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      idx_d  = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= dcf_pkg::IDX_SEL_ADDR;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q   <= in_cmd_i.op;
      mask_q <= in_cmd_i.mask;
      data_q <= data_d;
    end
  end

  assign dsel = idx_q[1:0] - dcf_pkg::IDX_DATA0[1:0];

  always_comb begin
    start_d = 1'b0;
    end_d   = 1'b0;
    case (idx_q)
      dcf_pkg::IDX_SEL_ADDR: begin
        byte_d  = dcf_pkg::ADDR_CHAN_SEL;
        start_d = 1'b1;
      end
      dcf_pkg::IDX_SEL_DATA: begin
        byte_d = {mask_q, 4'h0};
        end_d  = 1'b1;
      end
      dcf_pkg::IDX_REG_ADDR: begin
        byte_d  = reg_addr;
        start_d = 1'b1;
      end
      default: begin
        case (dsel)
          2'd0:    byte_d = data_q[31:24];
          2'd1:    byte_d = data_q[23:16];
          2'd2:    byte_d = data_q[15:8];
          default: byte_d = data_q[7:0];
        endcase
        end_d = (idx_q == last_idx);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= byte_d;
    out_start_q <= start_d;
    out_end_q   <= end_d;
    out_last_q  <= at_last;
  end

  assign result_valid_o = out_valid_q;
  assign bus_byte_o     = out_byte_q;
  assign frame_start_o  = out_start_q;
  assign frame_end_o    = out_end_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire
